>>> src/quaternion_multiply_rotate_defines.svh
`ifndef QUATERNION_MULTIPLY_ROTATE_DEFINES_SVH
`define QUATERNION_MULTIPLY_ROTATE_DEFINES_SVH

// same-cycle implication
`define QMR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QMR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/qmr_pkg.sv
package qmr_pkg;

    localparam int FRAC_BITS = 14;
    localparam int CW        = 16;
    localparam int HW        = 20;
    localparam int MW        = HW;
    localparam int SW        = 2 * MW + 2;
    localparam int RW        = SW / 2;
    localparam int QB        = FRAC_BITS + 1;
    localparam int NW        = MW + FRAC_BITS + 1;
    localparam int PW        = 2 * CW + 2;
    localparam int OQ_DEPTH  = 4;
    localparam int OQ_PW     = $clog2(OQ_DEPTH);
    localparam int OQ_CW     = OQ_PW + 1;

    localparam logic [QB-1:0] ONE_Q = QB'(1) << FRAC_BITS;

    typedef logic signed [CW-1:0] t_c16;
    typedef t_c16 [3:0]           t_q16;
    typedef logic signed [HW-1:0] t_ch;
    typedef t_ch [3:0]            t_qh;

    typedef struct packed {
        logic vld;
        logic kind;
        logic err;
        t_q16 aux;
    } t_side;

    typedef struct packed {
        logic kind;
        t_qh  v;
        t_qh  c;
        t_q16 a;
        t_q16 b;
    } t_job;

    typedef struct packed {
        t_q16 q;
        logic err;
    } t_res;

endpackage

>>> src/quaternion_multiply_rotate.sv
// Throughput: one transaction per cycle while the result queue has room; the four normalisers are
// fully pipelined (21 square-root stages and 15 divide stages each), so no unit is shared.
// A full result queue stalls the whole datapath; the input queue holds two transactions.
// Reset: synchronous, active low; empties both queues and clears all pipeline valids.
`include "quaternion_multiply_rotate_defines.svh"

module quaternion_multiply_rotate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_kind,
    input  logic signed [15:0] i_a_w,
    input  logic signed [15:0] i_a_x,
    input  logic signed [15:0] i_a_y,
    input  logic signed [15:0] i_a_z,
    input  logic signed [15:0] i_b_w,
    input  logic signed [15:0] i_b_x,
    input  logic signed [15:0] i_b_y,
    input  logic signed [15:0] i_b_z,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_r_w,
    output logic signed [15:0] o_r_x,
    output logic signed [15:0] o_r_y,
    output logic signed [15:0] o_r_z,
    output logic               o_zero_error
);

    logic          w_fvalid;
    logic          w_take;
    qmr_pkg::t_job w_job;
    qmr_pkg::t_res w_res;

    qmr_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_full (full),
        .i_kind (i_kind),
        .i_a_w  (i_a_w),
        .i_a_x  (i_a_x),
        .i_a_y  (i_a_y),
        .i_a_z  (i_a_z),
        .i_b_w  (i_b_w),
        .i_b_x  (i_b_x),
        .i_b_y  (i_b_y),
        .i_b_z  (i_b_z),
        .o_valid(w_fvalid),
        .i_take (w_take),
        .o_job  (w_job)
    );

    qmr_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_fvalid),
        .o_take (w_take),
        .i_job  (w_job),
        .o_empty(empty),
        .i_pop  (pop),
        .o_res  (w_res)
    );

    assign o_r_w        = w_res.q[0];
    assign o_r_x        = w_res.q[1];
    assign o_r_y        = w_res.q[2];
    assign o_r_z        = w_res.q[3];
    assign o_zero_error = w_res.err;

    `QMR_ASSERT_IMP(a_take_valid, w_take, w_fvalid, "take without queued transaction")
    `QMR_ASSERT_NXT(a_full_hold, full && !w_take, full, "input queue lost an entry")
    `QMR_ASSERT_IMP(a_err_zero, !empty && o_zero_error, o_r_w == 16'sd0 && o_r_x == 16'sd0, "err")
    `QMR_ASSERT_IMP(a_unit_w, !empty, o_r_w <= 16'sd16384 && o_r_w >= -16'sd16384, "w range")

endmodule

>>> src/qmr_front.sv
module qmr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic                i_kind,
    input  logic signed [15:0]  i_a_w,
    input  logic signed [15:0]  i_a_x,
    input  logic signed [15:0]  i_a_y,
    input  logic signed [15:0]  i_a_z,
    input  logic signed [15:0]  i_b_w,
    input  logic signed [15:0]  i_b_x,
    input  logic signed [15:0]  i_b_y,
    input  logic signed [15:0]  i_b_z,
    output logic                o_valid,
    input  logic                i_take,
    output qmr_pkg::t_job       o_job
);

    qmr_pkg::t_job n_job;
    qmr_pkg::t_job r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_in;
    logic          w_out;

    // rotate operands: pure vector from b, conjugate of a
    always_comb begin
        n_job.kind = i_kind;
        n_job.a[0] = i_a_w;
        n_job.a[1] = i_a_x;
        n_job.a[2] = i_a_y;
        n_job.a[3] = i_a_z;
        n_job.b[0] = i_b_w;
        n_job.b[1] = i_b_x;
        n_job.b[2] = i_b_y;
        n_job.b[3] = i_b_z;
        n_job.v[0] = '0;
        n_job.v[1] = qmr_pkg::t_ch'(i_b_x);
        n_job.v[2] = qmr_pkg::t_ch'(i_b_y);
        n_job.v[3] = qmr_pkg::t_ch'(i_b_z);
        n_job.c[0] = qmr_pkg::t_ch'(i_a_w);
        n_job.c[1] = -qmr_pkg::t_ch'(i_a_x);
        n_job.c[2] = -qmr_pkg::t_ch'(i_a_y);
        n_job.c[3] = -qmr_pkg::t_ch'(i_a_z);
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];
    assign w_in    = i_push & ~o_full;
    assign w_out   = i_take & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) begin
                r_q[r_wp] <= n_job;
                r_wp      <= ~r_wp;
            end
            if (w_out) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end

endmodule

>>> src/qmr_unitize.sv
module qmr_unitize (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  qmr_pkg::t_qh   i_q,
    input  qmr_pkg::t_side i_side,
    output qmr_pkg::t_q16  o_q,
    output logic           o_zero,
    output qmr_pkg::t_side o_side
);

    typedef struct packed {
        qmr_pkg::t_side                   side;
        logic                             zero;
        logic [3:0]                       neg;
        logic [3:0][qmr_pkg::MW-1:0]      mag;
    } t_car;

    t_car                                 n_car0;
    t_car                                 r_car0;
    t_car                                 r_car1;
    t_car                                 n_car2;
    t_car                                 r_car2;
    logic [3:0][2*qmr_pkg::MW-1:0]        r_sq;
    logic [qmr_pkg::SW-1:0]               n_sum;
    logic [qmr_pkg::SW-1:0]               r_sum;

    logic [qmr_pkg::RW+1:0]               r_rt_rem  [qmr_pkg::RW];
    logic [qmr_pkg::RW-1:0]               r_rt_root [qmr_pkg::RW];
    logic [qmr_pkg::SW-1:0]               r_rt_s    [qmr_pkg::RW];
    t_car                                 r_rt_car  [qmr_pkg::RW];

    logic [3:0][qmr_pkg::NW-1:0]          n_num;
    logic [3:0][qmr_pkg::RW-1:0]          r_d0_rem;
    logic [3:0][qmr_pkg::QB-1:0]          r_d0_low;
    logic [qmr_pkg::RW-1:0]               r_d0_root;
    t_car                                 r_d0_car;

    logic [3:0][qmr_pkg::RW-1:0]          r_dv_rem  [qmr_pkg::QB];
    logic [3:0][qmr_pkg::QB-1:0]          r_dv_q    [qmr_pkg::QB];
    logic [3:0][qmr_pkg::QB-1:0]          r_dv_low  [qmr_pkg::QB];
    logic [qmr_pkg::RW-1:0]               r_dv_root [qmr_pkg::QB];
    t_car                                 r_dv_car  [qmr_pkg::QB];

    qmr_pkg::t_q16                        n_out;
    qmr_pkg::t_q16                        r_q;
    logic                                 r_zero;
    qmr_pkg::t_side                       r_side;

    // magnitudes and signs
    always_comb begin
        n_car0      = '0;
        n_car0.side = i_side;
        for (int i = 0; i < 4; i++) begin
            n_car0.neg[i] = i_q[i][qmr_pkg::HW-1];
            n_car0.mag[i] = i_q[i][qmr_pkg::HW-1] ? qmr_pkg::MW'(-i_q[i])
                                                  : qmr_pkg::MW'(i_q[i]);
        end
    end

    always_comb begin
        n_sum = qmr_pkg::SW'(r_sq[0]) + qmr_pkg::SW'(r_sq[1])
              + qmr_pkg::SW'(r_sq[2]) + qmr_pkg::SW'(r_sq[3]);
        n_car2      = r_car1;
        n_car2.zero = (n_sum == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car0 <= '0;
            r_car1 <= '0;
            r_car2 <= '0;
            r_sq   <= '0;
            r_sum  <= '0;
        end else if (i_en) begin
            r_car0 <= n_car0;
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= r_car0.mag[i] * r_car0.mag[i];
            end
            r_car1 <= r_car0;
            r_sum  <= n_sum;
            r_car2 <= n_car2;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < qmr_pkg::RW; k++) begin : g_rt
        logic [qmr_pkg::RW+1:0] w_rem;
        logic [qmr_pkg::RW-1:0] w_root;
        logic [qmr_pkg::SW-1:0] w_s;
        t_car                   w_car;
        logic [qmr_pkg::RW+1:0] n_rs;
        logic [qmr_pkg::RW+1:0] n_trial;
        logic [qmr_pkg::RW+1:0] n_rem;
        logic                   n_ge;

        if (k == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_s    = r_sum;
            assign w_car  = r_car2;
        end else begin : g_next
            assign w_rem  = r_rt_rem[k-1];
            assign w_root = r_rt_root[k-1];
            assign w_s    = r_rt_s[k-1];
            assign w_car  = r_rt_car[k-1];
        end

        assign n_rs    = {w_rem[qmr_pkg::RW-1:0], w_s[qmr_pkg::SW-1-2*k -: 2]};
        assign n_trial = {w_root, 2'b01};
        assign n_ge    = (n_rs >= n_trial);
        assign n_rem   = n_ge ? n_rs - n_trial : n_rs;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_rem[k]  <= '0;
                r_rt_root[k] <= '0;
                r_rt_s[k]    <= '0;
                r_rt_car[k]  <= '0;
            end else if (i_en) begin
                r_rt_rem[k]  <= n_rem;
                r_rt_root[k] <= {w_root[qmr_pkg::RW-2:0], n_ge};
                r_rt_s[k]    <= w_s;
                r_rt_car[k]  <= w_car;
            end
        end
    end

    // rounded numerator |c| * ONE + root / 2
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_num[i] = (qmr_pkg::NW'(r_rt_car[qmr_pkg::RW-1].mag[i]) << qmr_pkg::FRAC_BITS)
                     + qmr_pkg::NW'(r_rt_root[qmr_pkg::RW-1] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_rem  <= '0;
            r_d0_low  <= '0;
            r_d0_root <= '0;
            r_d0_car  <= '0;
        end else if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_d0_rem[i] <= qmr_pkg::RW'(n_num[i] >> qmr_pkg::QB);
                r_d0_low[i] <= n_num[i][qmr_pkg::QB-1:0];
            end
            r_d0_root <= r_rt_root[qmr_pkg::RW-1];
            r_d0_car  <= r_rt_car[qmr_pkg::RW-1];
        end
    end

    // restoring division, one quotient bit per stage, four lanes
    for (genvar j = 0; j < qmr_pkg::QB; j++) begin : g_dv
        logic [3:0][qmr_pkg::RW-1:0] w_rem;
        logic [3:0][qmr_pkg::QB-1:0] w_q;
        logic [3:0][qmr_pkg::QB-1:0] w_low;
        logic [qmr_pkg::RW-1:0]      w_root;
        t_car                        w_car;
        logic [3:0][qmr_pkg::RW-1:0] n_rem;
        logic [3:0][qmr_pkg::QB-1:0] n_q;

        if (j == 0) begin : g_first
            assign w_rem  = r_d0_rem;
            assign w_q    = '0;
            assign w_low  = r_d0_low;
            assign w_root = r_d0_root;
            assign w_car  = r_d0_car;
        end else begin : g_next
            assign w_rem  = r_dv_rem[j-1];
            assign w_q    = r_dv_q[j-1];
            assign w_low  = r_dv_low[j-1];
            assign w_root = r_dv_root[j-1];
            assign w_car  = r_dv_car[j-1];
        end

        always_comb begin
            logic [qmr_pkg::RW:0] rs;
            logic                 ge;
            for (int i = 0; i < 4; i++) begin
                rs       = {w_rem[i], w_low[i][qmr_pkg::QB-1-j]};
                ge       = (rs >= {1'b0, w_root});
                n_rem[i] = ge ? qmr_pkg::RW'(rs - {1'b0, w_root}) : qmr_pkg::RW'(rs);
                n_q[i]   = {w_q[i][qmr_pkg::QB-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_rem[j]  <= '0;
                r_dv_q[j]    <= '0;
                r_dv_low[j]  <= '0;
                r_dv_root[j] <= '0;
                r_dv_car[j]  <= '0;
            end else if (i_en) begin
                r_dv_rem[j]  <= n_rem;
                r_dv_q[j]    <= n_q;
                r_dv_low[j]  <= w_low;
                r_dv_root[j] <= w_root;
                r_dv_car[j]  <= w_car;
            end
        end
    end

    always_comb begin
        logic [qmr_pkg::QB-1:0] v;
        for (int i = 0; i < 4; i++) begin
            v = (r_dv_q[qmr_pkg::QB-1][i] > qmr_pkg::ONE_Q) ? qmr_pkg::ONE_Q
                                                            : r_dv_q[qmr_pkg::QB-1][i];
            if (r_dv_car[qmr_pkg::QB-1].zero) begin
                n_out[i] = '0;
            end else if (r_dv_car[qmr_pkg::QB-1].neg[i]) begin
                n_out[i] = -qmr_pkg::CW'(v);
            end else begin
                n_out[i] = qmr_pkg::CW'(v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q    <= '0;
            r_zero <= 1'b0;
            r_side <= '0;
        end else if (i_en) begin
            r_q    <= n_out;
            r_zero <= r_dv_car[qmr_pkg::QB-1].zero;
            r_side <= r_dv_car[qmr_pkg::QB-1].side;
        end
    end

    assign o_q    = r_q;
    assign o_zero = r_zero;
    assign o_side = r_side;

endmodule

>>> src/qmr_hamilton.sv
module qmr_hamilton (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  qmr_pkg::t_q16  i_p,
    input  qmr_pkg::t_q16  i_q,
    input  qmr_pkg::t_side i_side,
    output qmr_pkg::t_qh   o_r,
    output qmr_pkg::t_side o_side
);

    logic signed [2*qmr_pkg::CW-1:0] r_prod [4][4];
    logic signed [qmr_pkg::PW-1:0]   n_sum  [4];
    logic signed [qmr_pkg::PW-1:0]   r_sum  [4];
    qmr_pkg::t_qh                    n_r;
    qmr_pkg::t_qh                    r_r;
    qmr_pkg::t_side                  r_side0;
    qmr_pkg::t_side                  r_side1;
    qmr_pkg::t_side                  r_side2;

    always_comb begin
        n_sum[0] = qmr_pkg::PW'(r_prod[0][0]) - qmr_pkg::PW'(r_prod[1][1])
                 - qmr_pkg::PW'(r_prod[2][2]) - qmr_pkg::PW'(r_prod[3][3]);
        n_sum[1] = qmr_pkg::PW'(r_prod[0][1]) + qmr_pkg::PW'(r_prod[1][0])
                 + qmr_pkg::PW'(r_prod[2][3]) - qmr_pkg::PW'(r_prod[3][2]);
        n_sum[2] = qmr_pkg::PW'(r_prod[0][2]) - qmr_pkg::PW'(r_prod[1][3])
                 + qmr_pkg::PW'(r_prod[2][0]) + qmr_pkg::PW'(r_prod[3][1]);
        n_sum[3] = qmr_pkg::PW'(r_prod[0][3]) + qmr_pkg::PW'(r_prod[1][2])
                 - qmr_pkg::PW'(r_prod[2][1]) + qmr_pkg::PW'(r_prod[3][0]);
    end

    // round half away from zero
    always_comb begin
        logic [qmr_pkg::PW-1:0] m;
        logic [qmr_pkg::PW-1:0] mr;
        for (int i = 0; i < 4; i++) begin
            m  = r_sum[i][qmr_pkg::PW-1] ? qmr_pkg::PW'(-r_sum[i]) : qmr_pkg::PW'(r_sum[i]);
            mr = (m + (qmr_pkg::PW'(1) << (qmr_pkg::FRAC_BITS - 1))) >> qmr_pkg::FRAC_BITS;
            n_r[i] = r_sum[i][qmr_pkg::PW-1] ? -qmr_pkg::HW'(mr) : qmr_pkg::HW'(mr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod  <= '{default: '0};
            r_sum   <= '{default: '0};
            r_r     <= '0;
            r_side0 <= '0;
            r_side1 <= '0;
            r_side2 <= '0;
        end else if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[i][j] <= $signed(i_p[i]) * $signed(i_q[j]);
                end
            end
            r_sum   <= n_sum;
            r_r     <= n_r;
            r_side0 <= i_side;
            r_side1 <= r_side0;
            r_side2 <= r_side1;
        end
    end

    assign o_r    = r_r;
    assign o_side = r_side2;

endmodule

>>> src/qmr_back.sv
module qmr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_take,
    input  qmr_pkg::t_job i_job,
    output logic          o_empty,
    input  logic          i_pop,
    output qmr_pkg::t_res o_res
);

    logic                        w_en;
    qmr_pkg::t_side              w_s0v_in;
    qmr_pkg::t_side              w_s0c_in;
    qmr_pkg::t_q16               w_uv;
    qmr_pkg::t_q16               w_uc;
    logic                        w_zv;
    logic                        w_zc;
    qmr_pkg::t_side              w_s0v;
    qmr_pkg::t_side              w_s0c;
    qmr_pkg::t_q16               w_p1;
    qmr_pkg::t_q16               w_q1;
    qmr_pkg::t_side              w_h1_in;
    qmr_pkg::t_qh                w_h1;
    qmr_pkg::t_side              w_h1_side;
    qmr_pkg::t_q16               w_t;
    logic                        w_z1;
    qmr_pkg::t_side              w_s1;
    qmr_pkg::t_q16               w_na;
    qmr_pkg::t_side              w_h2_in;
    qmr_pkg::t_qh                w_h2;
    qmr_pkg::t_side              w_h2_side;
    qmr_pkg::t_q16               w_u2;
    logic                        w_z2;
    qmr_pkg::t_side              w_s2;
    qmr_pkg::t_res               n_res;
    logic                        w_push;
    logic                        w_pop;

    qmr_pkg::t_res               r_oq [qmr_pkg::OQ_DEPTH];
    logic [qmr_pkg::OQ_PW-1:0]   r_wp;
    logic [qmr_pkg::OQ_PW-1:0]   r_rp;
    logic [qmr_pkg::OQ_CW-1:0]   r_cnt;

    // pipeline advances while the result queue has room
    assign w_en   = (r_cnt != qmr_pkg::OQ_CW'(qmr_pkg::OQ_DEPTH));
    assign o_take = w_en & i_valid;

    always_comb begin
        w_s0v_in      = '0;
        w_s0v_in.vld  = o_take;
        w_s0v_in.kind = i_job.kind;
        w_s0v_in.aux  = i_job.a;
        w_s0c_in      = '0;
        w_s0c_in.vld  = o_take;
        w_s0c_in.kind = i_job.kind;
        w_s0c_in.aux  = i_job.b;
    end

    qmr_unitize u_n0v (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_q    (i_job.v),
        .i_side (w_s0v_in),
        .o_q    (w_uv),
        .o_zero (w_zv),
        .o_side (w_s0v)
    );

    qmr_unitize u_n0c (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_q    (i_job.c),
        .i_side (w_s0c_in),
        .o_q    (w_uc),
        .o_zero (w_zc),
        .o_side (w_s0c)
    );

    // product: a*b as given; rotate: v*c after normalising both
    always_comb begin
        w_p1         = w_s0v.kind ? w_uv : w_s0v.aux;
        w_q1         = w_s0v.kind ? w_uc : w_s0c.aux;
        w_h1_in      = '0;
        w_h1_in.vld  = w_s0v.vld;
        w_h1_in.kind = w_s0v.kind;
        w_h1_in.err  = w_s0v.kind & (w_zv | w_zc);
        w_h1_in.aux  = w_uc;
    end

    qmr_hamilton u_h1 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_p    (w_p1),
        .i_q    (w_q1),
        .i_side (w_h1_in),
        .o_r    (w_h1),
        .o_side (w_h1_side)
    );

    qmr_unitize u_n1 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_q    (w_h1),
        .i_side (w_h1_side),
        .o_q    (w_t),
        .o_zero (w_z1),
        .o_side (w_s1)
    );

    always_comb begin
        w_na[0]      = w_s1.aux[0];
        w_na[1]      = -w_s1.aux[1];
        w_na[2]      = -w_s1.aux[2];
        w_na[3]      = -w_s1.aux[3];
        w_h2_in      = '0;
        w_h2_in.vld  = w_s1.vld;
        w_h2_in.kind = w_s1.kind;
        w_h2_in.err  = w_s1.err | w_z1;
        w_h2_in.aux  = w_t;
    end

    qmr_hamilton u_h2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_p    (w_na),
        .i_q    (w_t),
        .i_side (w_h2_in),
        .o_r    (w_h2),
        .o_side (w_h2_side)
    );

    qmr_unitize u_n2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_q    (w_h2),
        .i_side (w_h2_side),
        .o_q    (w_u2),
        .o_zero (w_z2),
        .o_side (w_s2)
    );

    always_comb begin
        n_res.err = w_s2.err | (w_s2.kind & w_z2);
        if (n_res.err) begin
            n_res.q = '0;
        end else begin
            n_res.q = w_s2.kind ? w_u2 : w_s2.aux;
        end
    end

    assign w_push  = w_en & w_s2.vld;
    assign o_empty = (r_cnt == '0);
    assign w_pop   = i_pop & ~o_empty;
    assign o_res   = r_oq[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_oq[r_wp] <= n_res;
                r_wp       <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + qmr_pkg::OQ_CW'(w_push) - qmr_pkg::OQ_CW'(w_pop);
        end
    end

endmodule
